// ===== rtl/core/pxhist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxhist_pkg
// Shared types for the per-pixel histogram background estimator.
// ----------------------------------------------------------------------------
package pxhist_pkg;

  localparam int PIX_BITS = 6;
  localparam int VAL_BITS = 8;
  localparam int CNT_BITS = 16;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [PIX_BITS-1:0] pix;
    logic [VAL_BITS-1:0] val;
    logic                last;
  } item_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_SCAN,
    B_DONE
  } back_state_t;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] x);
    sat_inc = (x == CNT_MAX) ? CNT_MAX : x + CNT_BITS'(1);
  endfunction

endpackage

// ===== rtl/core/pxhist_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxhist_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pxhist_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pxhist_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxhist_front
// Accepts samples, drops those outside the unit, clamps the value and
// queues them for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module pxhist_front #(
  parameter int UNIT_PIXELS  = 64,
  parameter int VALUE_LEVELS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic [pxhist_pkg::PIX_BITS-1:0] pixel_index,
  input  logic [pxhist_pkg::VAL_BITS-1:0] sample_value,
  input  logic                          last_frame,
  input  logic                          clearing,
  output logic                          q_valid,
  output pxhist_pkg::item_t             q_item,
  input  logic                          q_ready
);

  pxhist_pkg::item_t ent [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              pix_ok;
  logic              push;
  logic              pop;
  pxhist_pkg::item_t in_item;

  assign sample_ready = !clearing && (fill != 2'd2);
  assign pix_ok       = 32'(pixel_index) < UNIT_PIXELS;
  assign push         = sample_valid && sample_ready && pix_ok;
  assign pop          = q_valid && q_ready;
  assign q_valid      = fill != 2'd0;
  assign q_item       = ent[rd_ptr];

  always_comb begin
    in_item.pix  = pixel_index;
    in_item.val  = (32'(sample_value) >= VALUE_LEVELS) ?
                   pxhist_pkg::VAL_BITS'(VALUE_LEVELS - 1) : sample_value;
    in_item.last = last_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= in_item;
    end
  end

endmodule

// ===== rtl/core/pxhist_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxhist_back
// Updates the histogram bin and sample count of each queued sample, scans
// and clears a pixel's histogram on its last frame, and holds the result.
// ----------------------------------------------------------------------------
module pxhist_back #(
  parameter int UNIT_PIXELS  = 64,
  parameter int VALUE_LEVELS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            method_select,
  input  logic                            q_valid,
  input  pxhist_pkg::item_t               q_item,
  output logic                            q_ready,
  output logic                            clearing,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [pxhist_pkg::PIX_BITS-1:0] out_pixel_index,
  output logic [pxhist_pkg::VAL_BITS-1:0] background_value
);

  localparam int PIX_N = (UNIT_PIXELS < 64) ? UNIT_PIXELS : 64;
  localparam int PW    = (PIX_N > 1) ? $clog2(PIX_N) : 1;
  localparam int VW    = $clog2(VALUE_LEVELS);
  localparam int AW    = PW + VW;
  localparam int HDEPTH = 1 << AW;
  localparam int CDEPTH = 1 << PW;
  localparam int SW    = pxhist_pkg::CNT_BITS + VW;
  localparam int CW    = pxhist_pkg::CNT_BITS;

  pxhist_pkg::back_state_t state;
  pxhist_pkg::back_state_t state_next;

  logic [AW-1:0]   clr_addr;
  pxhist_pkg::item_t cur;
  logic [CW-1:0]   cnt_reg;
  logic [VW:0]     iss_v;
  logic [VW-1:0]   proc_v;
  logic            data_valid;
  logic [VW-1:0]   best;
  logic [CW-1:0]   best_count;
  logic [SW-1:0]   seen;
  logic            found;
  logic [VW-1:0]   med;
  logic            mode_sel;

  logic            h_we;
  logic [AW-1:0]   h_waddr;
  logic [CW-1:0]   h_wdata;
  logic [AW-1:0]   h_raddr;
  logic [CW-1:0]   h_rdata;
  logic            c_we;
  logic [PW-1:0]   c_waddr;
  logic [CW-1:0]   c_wdata;
  logic [PW-1:0]   c_raddr;
  logic [CW-1:0]   c_rdata;

  logic            issuing;
  logic            scan_end;
  logic            out_free;
  logic [CW-1:0]   bin_inc;
  logic [CW-1:0]   cnt_inc;
  logic [SW-1:0]   seen_sum;
  logic [VW-1:0]   result_v;

  pxhist_ram #(.WIDTH(CW), .DEPTH(HDEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  pxhist_ram #(.WIDTH(CW), .DEPTH(CDEPTH)) u_count_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  assign issuing  = iss_v < (VW+1)'(VALUE_LEVELS);
  assign scan_end = data_valid && (proc_v == VW'(VALUE_LEVELS - 1));
  assign out_free = !result_valid || result_ready;
  assign bin_inc  = pxhist_pkg::sat_inc(h_rdata);
  assign cnt_inc  = pxhist_pkg::sat_inc(c_rdata);
  assign seen_sum = seen + SW'(h_rdata);
  assign result_v = mode_sel ? (found ? med : VW'(VALUE_LEVELS - 1)) : best;

  always_comb begin
    state_next = state;
    unique case (state)
      pxhist_pkg::B_CLEAR: begin
        if (clr_addr == AW'(HDEPTH - 1)) begin
          state_next = pxhist_pkg::B_IDLE;
        end
      end
      pxhist_pkg::B_IDLE: begin
        if (q_valid) begin
          state_next = pxhist_pkg::B_READ;
        end
      end
      pxhist_pkg::B_READ: begin
        state_next = cur.last ? pxhist_pkg::B_SCAN : pxhist_pkg::B_IDLE;
      end
      pxhist_pkg::B_SCAN: begin
        if (scan_end) begin
          state_next = pxhist_pkg::B_DONE;
        end
      end
      pxhist_pkg::B_DONE: begin
        if (out_free) begin
          state_next = pxhist_pkg::B_IDLE;
        end
      end
      default: state_next = pxhist_pkg::B_CLEAR;
    endcase
  end

  always_comb begin
    q_ready  = 1'b0;
    clearing = 1'b0;
    h_we     = 1'b0;
    h_waddr  = {cur.pix[PW-1:0], cur.val[VW-1:0]};
    h_wdata  = '0;
    h_raddr  = {q_item.pix[PW-1:0], q_item.val[VW-1:0]};
    c_we     = 1'b0;
    c_waddr  = cur.pix[PW-1:0];
    c_wdata  = '0;
    c_raddr  = q_item.pix[PW-1:0];
    unique case (state)
      pxhist_pkg::B_CLEAR: begin
        clearing = 1'b1;
        h_we     = 1'b1;
        h_waddr  = clr_addr;
        c_we     = 1'b1;
        c_waddr  = clr_addr[PW-1:0];
      end
      pxhist_pkg::B_IDLE: begin
        q_ready = 1'b1;
      end
      pxhist_pkg::B_READ: begin
        h_we    = 1'b1;
        h_wdata = bin_inc;
        c_we    = 1'b1;
        c_wdata = cur.last ? '0 : cnt_inc;
      end
      pxhist_pkg::B_SCAN: begin
        h_raddr = {cur.pix[PW-1:0], iss_v[VW-1:0]};
        h_we    = data_valid;
        h_waddr = {cur.pix[PW-1:0], proc_v};
      end
      pxhist_pkg::B_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pxhist_pkg::B_CLEAR;
      clr_addr     <= '0;
      data_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pxhist_pkg::B_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      data_valid <= (state == pxhist_pkg::B_SCAN) && issuing;
      if (state == pxhist_pkg::B_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pxhist_pkg::B_IDLE && q_valid) begin
      cur <= q_item;
    end
    if (state == pxhist_pkg::B_READ) begin
      cnt_reg    <= cnt_inc;
      mode_sel   <= method_select;
      iss_v      <= '0;
      best       <= '0;
      best_count <= '0;
      seen       <= '0;
      found      <= 1'b0;
      med        <= '0;
    end
    if (state == pxhist_pkg::B_SCAN) begin
      if (issuing) begin
        iss_v <= iss_v + (VW+1)'(1);
      end
      proc_v <= iss_v[VW-1:0];
      if (data_valid) begin
        if (h_rdata > best_count) begin
          best_count <= h_rdata;
          best       <= proc_v;
        end
        seen <= seen_sum;
        if (!found && seen_sum > SW'(cnt_reg >> 1)) begin
          found <= 1'b1;
          med   <= proc_v;
        end
      end
    end
    if (state == pxhist_pkg::B_DONE && out_free) begin
      out_pixel_index  <= cur.pix;
      background_value <= pxhist_pkg::VAL_BITS'(result_v);
    end
  end

  a_median_found: assert property (@(posedge clk) disable iff (rst)
    (state == pxhist_pkg::B_DONE && mode_sel) |-> found)
    else $error("median scan ended without crossing half the count");

  a_mode_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == pxhist_pkg::B_DONE && !mode_sel) |-> (best_count != '0))
    else $error("mode scan found an empty histogram");

  a_last_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (state == pxhist_pkg::B_READ && cur.last) |=>
      (state == pxhist_pkg::B_SCAN && iss_v == '0 && !data_valid))
    else $error("last-frame sample did not start a fresh scan");

  a_scan_clear_lags_read: assert property (@(posedge clk) disable iff (rst)
    (state == pxhist_pkg::B_SCAN && data_valid) |-> (iss_v == (VW+1)'(proc_v) + (VW+1)'(1)))
    else $error("scan clear address out of step with read address");

endmodule

// ===== rtl/core/pixel_histogram_mode_median_background_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_histogram_mode_median_background_top
// Per-pixel histogram background estimator producing the mode or median.
// ----------------------------------------------------------------------------
//  Channel  Handshake                     Payload
//  sample   sample_valid / sample_ready   pixel_index, sample_value, last_frame
//  result   result_valid / result_ready   out_pixel_index, background_value
//  config   cfg_write_en                  cfg_write_data (method select)
//
// In the back end a sample that is not a last frame has its bin and count
// read, then written back. A last-frame sample also starts a bin scan that
// reads and clears one histogram entry per cycle.
// After reset a clearing pass writes each of the 2^(PW+VW) histogram entries
// once (16384 at the default sizes), while no sample is accepted.
// A two-entry queue lets the input side keep accepting while the back end
// scans or waits for a result transfer to be taken.
// ----------------------------------------------------------------------------
module pixel_histogram_mode_median_background_top #(
  parameter int UNIT_PIXELS  = 64,
  parameter int VALUE_LEVELS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic                            cfg_write_data,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  logic [pxhist_pkg::PIX_BITS-1:0] pixel_index,
  input  logic [pxhist_pkg::VAL_BITS-1:0] sample_value,
  input  logic                            last_frame,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [pxhist_pkg::PIX_BITS-1:0] out_pixel_index,
  output logic [pxhist_pkg::VAL_BITS-1:0] background_value
);

  logic              method_select;
  logic              clearing;
  logic              q_valid;
  logic              q_ready;
  pxhist_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      method_select <= 1'b0;
    end else if (cfg_write_en) begin
      method_select <= cfg_write_data;
    end
  end

  pxhist_front #(
    .UNIT_PIXELS  (UNIT_PIXELS),
    .VALUE_LEVELS (VALUE_LEVELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .pixel_index  (pixel_index),
    .sample_value (sample_value),
    .last_frame   (last_frame),
    .clearing     (clearing),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_ready      (q_ready)
  );

  pxhist_back #(
    .UNIT_PIXELS  (UNIT_PIXELS),
    .VALUE_LEVELS (VALUE_LEVELS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .method_select    (method_select),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_ready          (q_ready),
    .clearing         (clearing),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .out_pixel_index  (out_pixel_index),
    .background_value (background_value)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-pixel histogram background estimator.
// A directed table covers the extremes, mode ties and both methods. Random
// interleaved pixel sequences follow, with random gaps and stalls on both
// channels. Each result is checked against the table value or, if none, a predictor.
// ----------------------------------------------------------------------------
module tb;
  localparam int PIX_BITS = pxhist_pkg::PIX_BITS;
  localparam int VAL_BITS = pxhist_pkg::VAL_BITS;
  localparam int CNT_BITS = pxhist_pkg::CNT_BITS;
  localparam logic [CNT_BITS-1:0] CNT_MAX = pxhist_pkg::CNT_MAX;

  localparam int UNIT_PIXELS  = 64;
  localparam int VALUE_LEVELS = 256;
  localparam int DRAIN_CYCLES = VALUE_LEVELS + 44;
  localparam int LONG_HOLD    = 400;
  localparam int DIR_ROWS     = 24;
  localparam int PHASE_ITEMS  = 175;

  typedef struct packed {
    logic [PIX_BITS-1:0] pix;
    logic [VAL_BITS-1:0] bg;
  } bg_result_t;

  typedef struct packed {
    logic                method;
    logic [PIX_BITS-1:0] pix;
    logic [VAL_BITS-1:0] val;
    logic                lastf;
    logic                typed;
    logic [VAL_BITS-1:0] bg;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write_en = 1'b0;
  logic                cfg_write_data = 1'b0;
  logic                sample_valid = 1'b0;
  logic                sample_ready;
  logic [PIX_BITS-1:0] pixel_index = '0;
  logic [VAL_BITS-1:0] sample_value = '0;
  logic                last_frame = 1'b0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [PIX_BITS-1:0] out_pixel_index;
  logic [VAL_BITS-1:0] background_value;

  bit [CNT_BITS-1:0] hist_pred [UNIT_PIXELS][VALUE_LEVELS];
  bit [CNT_BITS-1:0] count_pred [UNIT_PIXELS];
  bit                method_pred;
  bit [VAL_BITS-1:0] seq_base [UNIT_PIXELS];

  bg_result_t bg_expect [$];
  int         errors = 0;
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;
  bit         rx_long_hold = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 6'd0,  8'd0,   1'b1, 1'b1, 8'd0},
    '{1'b0, 6'd63, 8'd255, 1'b1, 1'b1, 8'd255},
    '{1'b0, 6'd1,  8'd7,   1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd1,  8'd3,   1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd1,  8'd200, 1'b1, 1'b1, 8'd3},
    '{1'b0, 6'd2,  8'd9,   1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd2,  8'd4,   1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd2,  8'd9,   1'b1, 1'b1, 8'd9},
    '{1'b0, 6'd7,  8'd100, 1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd8,  8'd50,  1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd7,  8'd100, 1'b1, 1'b1, 8'd100},
    '{1'b0, 6'd8,  8'd60,  1'b1, 1'b1, 8'd50},
    '{1'b1, 6'd3,  8'd255, 1'b1, 1'b1, 8'd255},
    '{1'b1, 6'd4,  8'd0,   1'b1, 1'b1, 8'd0},
    '{1'b1, 6'd5,  8'd10,  1'b0, 1'b0, 8'd0},
    '{1'b1, 6'd5,  8'd30,  1'b0, 1'b0, 8'd0},
    '{1'b1, 6'd5,  8'd20,  1'b1, 1'b0, 8'd0},
    '{1'b1, 6'd6,  8'd200, 1'b0, 1'b0, 8'd0},
    '{1'b1, 6'd6,  8'd100, 1'b1, 1'b0, 8'd0},
    '{1'b1, 6'd62, 8'd128, 1'b0, 1'b0, 8'd0},
    '{1'b1, 6'd62, 8'd128, 1'b0, 1'b0, 8'd0},
    '{1'b1, 6'd62, 8'd1,   1'b1, 1'b0, 8'd0},
    '{1'b0, 6'd9,  8'd255, 1'b0, 1'b0, 8'd0},
    '{1'b0, 6'd9,  8'd0,   1'b1, 1'b1, 8'd0}
  };

  pixel_histogram_mode_median_background_top #(
    .UNIT_PIXELS  (UNIT_PIXELS),
    .VALUE_LEVELS (VALUE_LEVELS)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .sample_valid     (sample_valid),
    .sample_ready     (sample_ready),
    .pixel_index      (pixel_index),
    .sample_value     (sample_value),
    .last_frame       (last_frame),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .out_pixel_index  (out_pixel_index),
    .background_value (background_value)
  );

  always #2 clk = ~clk;

  task automatic absorb_sample(input logic [PIX_BITS-1:0] pix, input logic [VAL_BITS-1:0] val,
                               input logic lastf, output logic has_bg,
                               output logic [VAL_BITS-1:0] bg);
    int unsigned half;
    int unsigned seen;
    int unsigned best_n;
    bit          found;
    has_bg = 1'b0;
    bg = '0;
    if (hist_pred[pix][val] != CNT_MAX) hist_pred[pix][val] = hist_pred[pix][val] + 1'b1;
    if (count_pred[pix] != CNT_MAX) count_pred[pix] = count_pred[pix] + 1'b1;
    if (lastf) begin
      has_bg = 1'b1;
      if (method_pred) begin
        half = count_pred[pix] / 2;
        seen = 0;
        found = 1'b0;
        bg = VAL_BITS'(VALUE_LEVELS - 1);
        for (int v = 0; v < VALUE_LEVELS; v++) begin
          if (!found) begin
            seen += hist_pred[pix][v];
            if (seen > half) begin
              bg = VAL_BITS'(v);
              found = 1'b1;
            end
          end
        end
      end else begin
        best_n = 0;
        for (int v = 0; v < VALUE_LEVELS; v++) begin
          if (hist_pred[pix][v] > best_n) begin
            best_n = hist_pred[pix][v];
            bg = VAL_BITS'(v);
          end
        end
      end
      for (int v = 0; v < VALUE_LEVELS; v++) hist_pred[pix][v] = '0;
      count_pred[pix] = '0;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer_sample(input logic [PIX_BITS-1:0] pix, input logic [VAL_BITS-1:0] val,
                              input logic lastf, input logic typed,
                              input logic [VAL_BITS-1:0] typed_bg);
    int                  gap;
    logic                has_bg;
    logic [VAL_BITS-1:0] bg;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    pixel_index  <= pix;
    sample_value <= val;
    last_frame   <= lastf;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    absorb_sample(pix, val, lastf, has_bg, bg);
    if (has_bg) bg_expect.push_back(bg_result_t'{pix, typed ? typed_bg : bg});
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    sample_valid <= 1'b0;
    while (bg_expect.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_method(input logic m);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= m;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    method_pred = m;
  endtask

  // Mostly short clustered sequences on a few pixels, with some full-range noise.
  task automatic draw_sample(output logic [PIX_BITS-1:0] pix, output logic [VAL_BITS-1:0] val,
                             output logic lastf);
    pix = ($urandom_range(0, 3) == 0) ? PIX_BITS'($urandom_range(0, UNIT_PIXELS - 1))
                                      : PIX_BITS'($urandom_range(0, 15));
    if (count_pred[pix] == 0) seq_base[pix] = VAL_BITS'($urandom_range(0, VALUE_LEVELS - 1));
    if ($urandom_range(0, 3) == 0) val = VAL_BITS'($urandom_range(0, VALUE_LEVELS - 1));
    else val = seq_base[pix] + VAL_BITS'($urandom_range(0, 3));
    lastf = ($urandom_range(0, 5) == 0);
  endtask

  initial begin
    int         stall;
    bg_result_t want;
    @(negedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 4);
      if (rx_long_hold) begin
        stall = LONG_HOLD;
        rx_long_hold = 1'b0;
      end
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      if (bg_expect.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, pixel %0d value %0d", $time,
                 out_pixel_index, background_value);
      end else begin
        want = bg_expect.pop_front();
        if (out_pixel_index !== want.pix) begin
          errors++;
          $display("%0t: out_pixel_index expected %0d actual %0d", $time, want.pix,
                   out_pixel_index);
        end
        if (background_value !== want.bg) begin
          errors++;
          $display("%0t: background_value expected %0d actual %0d", $time, want.bg,
                   background_value);
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    dir_row_t            row;
    logic [PIX_BITS-1:0] pix;
    logic [VAL_BITS-1:0] val;
    logic                lastf;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    set_method(1'b0);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.method != method_pred) begin
        wait_results_done();
        set_method(row.method);
      end
      offer_sample(row.pix, row.val, row.lastf, row.typed, row.bg);
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_results_done();
      set_method((ph % 2) == 0);
      tx_calm = (ph == 3);
      rx_calm = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == 60) begin
          tx_calm = 1'b0;
          rx_calm = 1'b0;
        end
        if (ph == 1 && n == 50) rx_long_hold = 1'b1;
        if (ph == 2 && n == 90) wait_results_done();
        draw_sample(pix, val, lastf);
        offer_sample(pix, val, lastf, 1'b0, 8'd0);
      end
    end

    wait_results_done();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
